// ----- hdl/id_pool_allocator_assert.svh -----
// assertion macros for the id pool allocator
`ifndef ID_POOL_ALLOCATOR_ASSERT_SVH
`define ID_POOL_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define IDP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("id pool allocator: assertion failed");
`define IDP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("id pool allocator: assertion failed");
`else
`define IDP_ASSERT(lbl, clk, rst_n, prop)
`define IDP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- hdl/idp_pkg.sv -----
`default_nettype none

package idp_pkg;

  localparam int WORD_W = 32;
  localparam int BIT_W  = 5;
  localparam logic [14:0] ID_BASE_RESET = 15'd100;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_EXHAUSTED   = 2'd1,
    STATUS_OUT_OF_POOL = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MODIFY,
    S_SCAN,
    S_DONE
  } state_e;

  typedef struct packed {
    op_e         operation;
    logic [15:0] release_id;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] assigned_id;
  } out_t;

endpackage

`default_nettype wire

// ----- hdl/idp_ram.sv -----
`default_nettype none

module idp_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                       wdata_i,
  input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- hdl/idp_ffz.sv -----
`default_nettype none

// lowest clear bit of one bitmap row
module idp_ffz (
  input  wire logic [idp_pkg::WORD_W-1:0] word_i,
  output logic                            found_o,
  output logic [idp_pkg::BIT_W-1:0]       idx_o,
  output logic [idp_pkg::WORD_W-1:0]      onehot_o
);

  logic [idp_pkg::WORD_W-1:0] free_bits;

  assign free_bits = ~word_i;
  assign found_o   = |free_bits;
  // isolate the lowest set bit of the free mask
  assign onehot_o  = free_bits & (~free_bits + idp_pkg::WORD_W'(1));

  always_comb begin
    idx_o = '0;
    for (int i = 0; i < idp_pkg::WORD_W; i++) begin
      if (onehot_o[i]) begin
        idx_o = idx_o | idp_pkg::BIT_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/id_pool_allocator.sv -----
// Identifier pool allocator. Slots are kept as an in-use bitmap in a RAM of
// 32-bit rows (ceil(POOL_SIZE/32) rows), cleared at reset by per-row valid
// flops, so the block is ready right after reset. A release inside the pool
// and an allocate that reuses the last released slot go through read,
// modify and done; a release outside the pool goes straight to done. An
// allocate that falls back to the lowest-free search walks the bitmap one
// row per cycle through the single RAM read port. One item is worked on at a
// time; a finished result waits in the output register while the next item
// is accepted, and a result that finds that register still full waits until
// it is taken.
`default_nettype none

`include "id_pool_allocator_assert.svh"

module id_pool_allocator #(
  parameter int POOL_SIZE = 1024
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_we_i,
  input  wire logic [14:0]    cfg_wdata_i,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire idp_pkg::in_t   in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output idp_pkg::out_t       out_data_o
);

  localparam int WORDS = (POOL_SIZE + idp_pkg::WORD_W - 1) / idp_pkg::WORD_W;
  localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int SW    = $clog2(POOL_SIZE);
  localparam int SXW   = WAW + idp_pkg::BIT_W;
  localparam int TAIL  = POOL_SIZE - (WORDS - 1) * idp_pkg::WORD_W;
  localparam logic [WAW-1:0] LAST_WORD = WAW'(WORDS - 1);
  localparam logic [idp_pkg::WORD_W:0] TAIL_ONES =
    ((idp_pkg::WORD_W + 1)'(1) << TAIL) - (idp_pkg::WORD_W + 1)'(1);
  // bits past the end of the pool read as taken
  localparam logic [idp_pkg::WORD_W-1:0] TAIL_MASK = ~TAIL_ONES[idp_pkg::WORD_W-1:0];

  idp_pkg::state_e state_q, state_d;
  idp_pkg::op_e    op_q, op_d;
  logic [WAW-1:0]  addr_q, addr_d;
  logic [idp_pkg::BIT_W-1:0] bit_q, bit_d;
  logic [WAW-1:0]  scan_addr_q, scan_addr_d;
  logic [WAW-1:0]  chk_addr_q, chk_addr_d;
  logic            chk_vld_q, chk_vld_d;
  logic [SW-1:0]   hint_q, hint_d;
  logic            hint_vld_q, hint_vld_d;
  logic [14:0]     id_base_q, id_base_d;
  logic [WORDS-1:0] row_vld_q, row_vld_d;
  idp_pkg::out_t   res_q, res_d;
  idp_pkg::out_t   out_q, out_d;
  logic            out_vld_q, out_vld_d;

  logic                       in_fire;
  logic [15:0]                rel_off;
  logic                       in_pool;
  logic [SXW-1:0]             rel_x;
  logic [SXW-1:0]             hint_x;
  logic [SXW-1:0]             cur_x;
  logic [SXW-1:0]             scan_x;
  logic                       ram_we;
  logic [WAW-1:0]             ram_waddr;
  logic [idp_pkg::WORD_W-1:0] ram_wdata;
  logic [WAW-1:0]             ram_raddr;
  logic [idp_pkg::WORD_W-1:0] ram_rdata;
  logic [idp_pkg::WORD_W-1:0] mod_word;
  logic [idp_pkg::WORD_W-1:0] bit_mask;
  logic [idp_pkg::WORD_W-1:0] scan_raw;
  logic [idp_pkg::WORD_W-1:0] scan_word;
  logic                       ffz_found;
  logic [idp_pkg::BIT_W-1:0]  ffz_idx;
  logic [idp_pkg::WORD_W-1:0] ffz_onehot;

  assign in_ready_o  = (state_q == idp_pkg::S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  assign rel_off = in_data_i.release_id - 16'(id_base_q);
  assign in_pool = (in_data_i.release_id >= 16'(id_base_q)) && (rel_off < 16'(POOL_SIZE));
  assign rel_x   = SXW'(rel_off[SW-1:0]);
  assign hint_x  = SXW'(hint_q);
  assign cur_x   = {addr_q, bit_q};
  assign scan_x  = {chk_addr_q, ffz_idx};

  assign mod_word  = row_vld_q[addr_q] ? ram_rdata : '0;
  assign bit_mask  = idp_pkg::WORD_W'(1) << bit_q;
  assign scan_raw  = row_vld_q[chk_addr_q] ? ram_rdata : '0;
  assign scan_word = scan_raw | ((chk_addr_q == LAST_WORD) ? TAIL_MASK : '0);
  assign ram_raddr = (state_q == idp_pkg::S_SCAN) ? scan_addr_q : addr_q;

  idp_ram #(
    .Width (idp_pkg::WORD_W),
    .Depth (WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  idp_ffz u_ffz (
    .word_i   (scan_word),
    .found_o  (ffz_found),
    .idx_o    (ffz_idx),
    .onehot_o (ffz_onehot)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      idp_pkg::S_IDLE: begin
        if (in_fire) begin
          if (in_data_i.operation == idp_pkg::OP_RELEASE) begin
            state_d = in_pool ? idp_pkg::S_READ : idp_pkg::S_DONE;
          end else begin
            state_d = hint_vld_q ? idp_pkg::S_READ : idp_pkg::S_SCAN;
          end
        end
      end
      idp_pkg::S_READ: begin
        state_d = idp_pkg::S_MODIFY;
      end
      idp_pkg::S_MODIFY: begin
        if (op_q == idp_pkg::OP_RELEASE || !mod_word[bit_q]) begin
          state_d = idp_pkg::S_DONE;
        end else begin
          state_d = idp_pkg::S_SCAN;
        end
      end
      idp_pkg::S_SCAN: begin
        if (chk_vld_q && (ffz_found || chk_addr_q == LAST_WORD)) begin
          state_d = idp_pkg::S_DONE;
        end
      end
      idp_pkg::S_DONE: begin
        if (!out_vld_q || out_ready_i) begin
          state_d = idp_pkg::S_IDLE;
        end
      end
      default: state_d = idp_pkg::S_IDLE;
    endcase
  end

  // datapath and bitmap access
  always_comb begin
    op_d        = op_q;
    addr_d      = addr_q;
    bit_d       = bit_q;
    scan_addr_d = scan_addr_q;
    chk_addr_d  = chk_addr_q;
    chk_vld_d   = chk_vld_q;
    hint_d      = hint_q;
    hint_vld_d  = hint_vld_q;
    id_base_d   = id_base_q;
    row_vld_d   = row_vld_q;
    res_d       = res_q;
    out_d       = out_q;
    out_vld_d   = out_vld_q;
    ram_we      = 1'b0;
    ram_waddr   = addr_q;
    ram_wdata   = mod_word;

    if (cfg_we_i) begin
      id_base_d = cfg_wdata_i;
    end
    if (out_vld_q && out_ready_i) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      idp_pkg::S_IDLE: begin
        if (in_fire) begin
          op_d = in_data_i.operation;
          if (in_data_i.operation == idp_pkg::OP_RELEASE) begin
            addr_d = rel_x[SXW-1:idp_pkg::BIT_W];
            bit_d  = rel_x[idp_pkg::BIT_W-1:0];
            res_d.status      = idp_pkg::STATUS_OUT_OF_POOL;
            res_d.assigned_id = '0;
          end else begin
            addr_d      = hint_x[SXW-1:idp_pkg::BIT_W];
            bit_d       = hint_x[idp_pkg::BIT_W-1:0];
            scan_addr_d = '0;
            chk_vld_d   = 1'b0;
          end
        end
      end
      idp_pkg::S_READ: begin
        // row read is in flight
      end
      idp_pkg::S_MODIFY: begin
        if (op_q == idp_pkg::OP_RELEASE) begin
          ram_we            = 1'b1;
          ram_wdata         = mod_word & ~bit_mask;
          hint_d            = cur_x[SW-1:0];
          hint_vld_d        = 1'b1;
          res_d.status      = idp_pkg::STATUS_OK;
          res_d.assigned_id = '0;
        end else if (!mod_word[bit_q]) begin
          ram_we            = 1'b1;
          ram_wdata         = mod_word | bit_mask;
          res_d.status      = idp_pkg::STATUS_OK;
          res_d.assigned_id = 16'(id_base_q) + 16'(cur_x[SW-1:0]);
        end else begin
          scan_addr_d = '0;
          chk_vld_d   = 1'b0;
        end
      end
      idp_pkg::S_SCAN: begin
        // one row issued and one row checked every cycle
        if (scan_addr_q != LAST_WORD) begin
          scan_addr_d = scan_addr_q + WAW'(1);
        end
        chk_addr_d = scan_addr_q;
        chk_vld_d  = 1'b1;
        if (chk_vld_q) begin
          if (ffz_found) begin
            ram_we            = 1'b1;
            ram_waddr         = chk_addr_q;
            ram_wdata         = scan_raw | ffz_onehot;
            res_d.status      = idp_pkg::STATUS_OK;
            res_d.assigned_id = 16'(id_base_q) + 16'(scan_x[SW-1:0]);
          end else if (chk_addr_q == LAST_WORD) begin
            res_d.status      = idp_pkg::STATUS_EXHAUSTED;
            res_d.assigned_id = '0;
          end
        end
      end
      idp_pkg::S_DONE: begin
        if (!out_vld_q || out_ready_i) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (ram_we) begin
      row_vld_d[ram_waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= idp_pkg::S_IDLE;
      scan_addr_q <= '0;
      chk_addr_q  <= '0;
      chk_vld_q   <= 1'b0;
      hint_q      <= '0;
      hint_vld_q  <= 1'b0;
      id_base_q   <= idp_pkg::ID_BASE_RESET;
      row_vld_q   <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_addr_q <= scan_addr_d;
      chk_addr_q  <= chk_addr_d;
      chk_vld_q   <= chk_vld_d;
      hint_q      <= hint_d;
      hint_vld_q  <= hint_vld_d;
      id_base_q   <= id_base_d;
      row_vld_q   <= row_vld_d;
      out_vld_q   <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    addr_q     <= addr_d;
    bit_q      <= bit_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  `IDP_ASSERT(a_err_has_no_id, clk_i, rst_ni, (out_valid_o && out_data_o.status != idp_pkg::STATUS_OK) |-> (out_data_o.assigned_id == 16'd0))
  `IDP_ASSERT(a_map_write_at_commit, clk_i, rst_ni, ram_we |-> (state_q == idp_pkg::S_MODIFY || state_q == idp_pkg::S_SCAN))
  `IDP_ASSERT(a_scan_in_range, clk_i, rst_ni, (state_q == idp_pkg::S_SCAN) |-> (scan_addr_q <= LAST_WORD && chk_addr_q <= LAST_WORD))
  `IDP_ASSERT_NEXT(a_release_sets_hint, clk_i, rst_ni, (state_q == idp_pkg::S_MODIFY && op_q == idp_pkg::OP_RELEASE), hint_vld_q)

endmodule

`default_nettype wire
